>>> hw/rtl/assert_macros.svh
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> hw/rtl/dgbs_pkg.sv
package dgbs_pkg;

  localparam int MU           = 64;
  localparam int KAP          = 8;
  localparam int EXP_BITS     = 16;
  localparam int TRIALS       = 1024;
  localparam int SIGMA_CENTER = 4;

  localparam int WORD_W     = 64;
  localparam int IDX_W      = 5;
  localparam int SAMPLE_W   = 10;
  localparam int SIDX_W     = 11;
  localparam int IN_DATA_W  = ((IDX_W + WORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_W + SIDX_W + 7) / 8) * 8;

  localparam int TABLE_DEPTH = 1 + KAP + EXP_BITS;
  localparam int TIDX_W      = $clog2(TABLE_DEPTH);
  localparam int SIGN_PHASE  = KAP + EXP_BITS + 1;
  localparam int PH_W        = $clog2(SIGN_PHASE + 1);
  localparam int TR_W        = $clog2(TRIALS + 1);
  localparam int MAG_W       = KAP + 1;
  localparam int DIFF_W      = MAG_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int SQ_EXT_W    = 2 ** PH_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_RAND = 1'b1
  } func_t;

  typedef struct packed {
    func_t             kind;
    logic [PH_W-1:0]   slot;
    logic              last;
    logic [WORD_W-1:0] word;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> hw/rtl/dgbs_front.sv
module dgbs_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dgbs_pkg::IN_DATA_W-1:0]  in_tdata,   // table_index, word
  input  logic                            in_tuser,   // func
  input  dgbs_pkg::fifo_stat_t            stat,
  output logic                            push,
  output dgbs_pkg::entry_t                push_data
);

  logic [dgbs_pkg::PH_W-1:0]   phase_r, phase_nxt;
  logic [dgbs_pkg::TR_W-1:0]   trial_r, trial_nxt;
  logic [dgbs_pkg::IDX_W-1:0]  idx;
  logic                        acc;
  logic                        is_load;
  logic                        load_ok;
  logic                        done;

  assign idx       = in_tdata[dgbs_pkg::IDX_W-1:0];
  assign in_tready = ~stat.full;
  assign acc       = in_tvalid & ~stat.full;
  assign is_load   = (dgbs_pkg::func_t'(in_tuser) == dgbs_pkg::FUNC_LOAD);
  assign load_ok   = (32'(idx) < 32'(dgbs_pkg::TABLE_DEPTH));
  assign done      = (trial_r == dgbs_pkg::TR_W'(dgbs_pkg::TRIALS));
  assign push      = acc & (is_load ? load_ok : ~done);

  always_comb begin
    push_data.kind = dgbs_pkg::func_t'(in_tuser);
    push_data.slot = is_load ? dgbs_pkg::PH_W'(idx) : phase_r;
    push_data.last = (trial_r == dgbs_pkg::TR_W'(dgbs_pkg::TRIALS - 1));
    push_data.word = in_tdata[dgbs_pkg::IDX_W +: dgbs_pkg::WORD_W];
  end

  always_comb begin
    phase_nxt = phase_r;
    trial_nxt = trial_r;
    if (acc && !is_load && !done) begin
      if (phase_r == dgbs_pkg::PH_W'(dgbs_pkg::SIGN_PHASE)) begin
        phase_nxt = '0;
        trial_nxt = trial_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      trial_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      trial_r <= trial_nxt;
    end
  end

endmodule

>>> hw/rtl/dgbs_fifo.sv
`include "assert_macros.svh"

module dgbs_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dgbs_pkg::entry_t     push_data,
  input  logic                 pop,
  output dgbs_pkg::entry_t     head,
  output dgbs_pkg::fifo_stat_t stat
);

  dgbs_pkg::entry_t                 mem_r [dgbs_pkg::FIFO_DEPTH];
  logic [dgbs_pkg::FIFO_AW-1:0]     wr_r, wr_nxt;
  logic [dgbs_pkg::FIFO_AW-1:0]     rd_r, rd_nxt;
  logic [dgbs_pkg::FIFO_CW-1:0]     cnt_r, cnt_nxt;

  assign head       = mem_r[rd_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == dgbs_pkg::FIFO_CW'(dgbs_pkg::FIFO_DEPTH));

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk, rst_n, push && stat.full, "push into full queue")
  `ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && stat.empty, "pop from empty queue")
  `ASSERT_AT(a_cnt_grow, clk, rst_n, push && !pop |=> cnt_r == $past(cnt_r) + 1'b1, "count slip")
  `ASSERT_AT(a_ptr_track, clk, rst_n, (wr_r - rd_r) == dgbs_pkg::FIFO_AW'(cnt_r), "pointer slip")

endmodule

>>> hw/rtl/dgbs_back.sv
module dgbs_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dgbs_pkg::entry_t                 head,
  input  dgbs_pkg::fifo_stat_t             stat,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dgbs_pkg::OUT_DATA_W-1:0]  out_tdata,  // sample, sample_index
  output logic                             out_tuser,  // accepted
  output logic                             out_tlast   // last_trial
);

  function automatic logic bernoulli(input logic [dgbs_pkg::WORD_W-1:0] prob,
                                     input logic [dgbs_pkg::WORD_W-1:0] rnd);
    logic [dgbs_pkg::WORD_W-1:0] mask;
    logic [dgbs_pkg::WORD_W-1:0] diff;
    logic [dgbs_pkg::WORD_W-1:0] lowest;
    mask   = {dgbs_pkg::WORD_W{1'b1}} >> (dgbs_pkg::WORD_W - dgbs_pkg::MU);
    diff   = (prob ^ rnd) & mask;
    lowest = diff & (~diff + 1'b1);
    return (diff == '0) | (|(prob & lowest));
  endfunction

  logic [dgbs_pkg::WORD_W-1:0]     table_r [dgbs_pkg::TABLE_DEPTH];
  logic                            laplace_r, laplace_nxt;
  logic [dgbs_pkg::KAP-1:0]        geo_r, geo_nxt;
  logic [dgbs_pkg::MAG_W-1:0]      mag_r, mag_nxt;
  logic                            acc_r, acc_nxt;
  logic [dgbs_pkg::SIDX_W-1:0]     acnt_r, acnt_nxt;
  logic                            ovalid_r, ovalid_nxt;
  logic [dgbs_pkg::SAMPLE_W-1:0]   osample_r, osample_nxt;
  logic                            oacc_r, oacc_nxt;
  logic [dgbs_pkg::SIDX_W-1:0]     osidx_r, osidx_nxt;
  logic                            olast_r, olast_nxt;

  logic [dgbs_pkg::TIDX_W-1:0]     rd_idx;
  logic [dgbs_pkg::WORD_W-1:0]     prob;
  logic                            bit_b;
  logic                            is_rand;
  logic                            is_sign;
  logic [dgbs_pkg::PH_W-1:0]       gi;
  logic [dgbs_pkg::PH_W-1:0]       ei;
  logic signed [dgbs_pkg::DIFF_W-1:0] d;
  logic signed [dgbs_pkg::SQ_W-1:0]   sq;
  logic [dgbs_pkg::SQ_EXT_W-1:0]   sq_ext;
  logic [dgbs_pkg::SAMPLE_W-1:0]   mag_ext;

  assign is_rand = (head.kind == dgbs_pkg::FUNC_RAND);
  assign is_sign = is_rand && (head.slot == dgbs_pkg::PH_W'(dgbs_pkg::SIGN_PHASE));
  assign pop     = ~stat.empty & (~is_sign | ~ovalid_r | out_tready);

  assign rd_idx = (32'(head.slot) < 32'(dgbs_pkg::TABLE_DEPTH))
                  ? head.slot[dgbs_pkg::TIDX_W-1:0] : '0;
  assign prob   = table_r[rd_idx];
  assign bit_b  = bernoulli(prob, head.word);

  assign gi      = head.slot - 1'b1;
  assign ei      = head.slot - dgbs_pkg::PH_W'(dgbs_pkg::KAP + 1);
  assign d       = $signed({1'b0, mag_r}) - $signed(dgbs_pkg::DIFF_W'(dgbs_pkg::SIGMA_CENTER));
  assign sq      = d * d;
  assign sq_ext  = dgbs_pkg::SQ_EXT_W'($unsigned(sq));
  assign mag_ext = dgbs_pkg::SAMPLE_W'(mag_r);

  always_comb begin
    laplace_nxt = laplace_r;
    geo_nxt     = geo_r;
    mag_nxt     = mag_r;
    acc_nxt     = acc_r;
    acnt_nxt    = acnt_r;
    osample_nxt = osample_r;
    oacc_nxt    = oacc_r;
    osidx_nxt   = osidx_r;
    olast_nxt   = olast_r;
    ovalid_nxt  = ovalid_r & ~out_tready;
    if (pop && is_rand) begin
      if (head.slot == '0) begin
        laplace_nxt = bit_b;
      end else if (32'(head.slot) <= 32'(dgbs_pkg::KAP)) begin
        geo_nxt = geo_r | (dgbs_pkg::KAP'(bit_b) << gi);
        if (head.slot == dgbs_pkg::PH_W'(dgbs_pkg::KAP)) begin
          mag_nxt = laplace_r ? '0 : dgbs_pkg::MAG_W'(geo_nxt) + 1'b1;
        end
      end else if (!is_sign) begin
        if (sq_ext[ei] && !bit_b) begin
          acc_nxt = 1'b0;
        end
      end else begin
        osample_nxt = head.word[0] ? (~mag_ext + 1'b1) : mag_ext;
        oacc_nxt    = acc_r;
        osidx_nxt   = acnt_r;
        olast_nxt   = head.last;
        ovalid_nxt  = 1'b1;
        acnt_nxt    = acnt_r + dgbs_pkg::SIDX_W'(acc_r);
        acc_nxt     = 1'b1;
        laplace_nxt = 1'b0;
        geo_nxt     = '0;
        mag_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !is_rand) begin
      table_r[rd_idx] <= head.word;
    end
  end

  always_ff @(posedge clk) begin
    osample_r <= osample_nxt;
    oacc_r    <= oacc_nxt;
    osidx_r   <= osidx_nxt;
    olast_r   <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      laplace_r <= 1'b0;
      geo_r     <= '0;
      mag_r     <= '0;
      acc_r     <= 1'b1;
      acnt_r    <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      laplace_r <= laplace_nxt;
      geo_r     <= geo_nxt;
      mag_r     <= mag_nxt;
      acc_r     <= acc_nxt;
      acnt_r    <= acnt_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = oacc_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = dgbs_pkg::OUT_DATA_W'({osidx_r, osample_r});

endmodule

>>> hw/rtl/discrete_gaussian_bernoulli_sampler_core.sv
// Throughput: one input item per cycle while the queue is not full; out_tready low
// stalls only sign items. A sign item is written into the queue, then popped after the
// items queued ahead of it, which registers its result and raises out_tvalid.
// Load and Bernoulli items give no result; a 4-entry queue decouples the front.
// Reset: synchronous, active low; clears phase, counters and output valid.
// The probability table has no reset and must be loaded before use.
module discrete_gaussian_bernoulli_sampler_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dgbs_pkg::IN_DATA_W-1:0]   in_tdata,   // table_index, word
  input  logic                             in_tuser,   // func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dgbs_pkg::OUT_DATA_W-1:0]  out_tdata,  // sample, sample_index
  output logic                             out_tuser,  // accepted
  output logic                             out_tlast   // last_trial
);

  logic                 push;
  logic                 pop;
  dgbs_pkg::entry_t     push_data;
  dgbs_pkg::entry_t     head;
  dgbs_pkg::fifo_stat_t stat;

  dgbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  dgbs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  dgbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sim/discrete_gaussian_bernoulli_sampler_core_test.sv
`timescale 1ns / 100ps

module discrete_gaussian_bernoulli_sampler_core_test;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    dgbs_pkg::func_t                 kind;
    logic [dgbs_pkg::IDX_W-1:0]      idx;
    logic [dgbs_pkg::WORD_W-1:0]     word;
  } sampler_item_t;

  typedef struct packed {
    logic [dgbs_pkg::SAMPLE_W-1:0]   sample;
    logic                            accepted;
    logic [dgbs_pkg::SIDX_W-1:0]     sidx;
    logic                            last;
  } trial_sample_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [dgbs_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // table_index, word
  logic                            in_tuser = 1'b0; // func
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [dgbs_pkg::OUT_DATA_W-1:0] out_tdata;       // sample, sample_index
  logic                            out_tuser;       // accepted
  logic                            out_tlast;       // last_trial

  discrete_gaussian_bernoulli_sampler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  sampler_item_t sampler_items[$];
  trial_sample_t expected_samples[$];
  sampler_item_t in_flight;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic rx_hold = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  // predictor state
  bit [dgbs_pkg::WORD_W-1:0] prob_words[dgbs_pkg::TABLE_DEPTH];
  int unsigned               step_phase;
  bit                        lap_bit;
  bit [dgbs_pkg::KAP-1:0]    geo_word;
  bit [dgbs_pkg::KAP:0]      mag;
  bit [31:0]                 sq_low;
  bit                        accept_ok;
  int unsigned               trials_done;
  int unsigned               accepts_done;

  // generator shadow
  bit [dgbs_pkg::WORD_W-1:0] gen_tab[dgbs_pkg::TABLE_DEPTH];
  int unsigned               gen_ph;
  int unsigned               gen_trials;
  int unsigned               gen_items;

  function automatic bit bernoulli_bit(bit [dgbs_pkg::WORD_W-1:0] p,
                                       bit [dgbs_pkg::WORD_W-1:0] r);
    bit [dgbs_pkg::WORD_W-1:0] mask;
    bit [dgbs_pkg::WORD_W-1:0] diff;
    bit [dgbs_pkg::WORD_W-1:0] low;
    mask = (dgbs_pkg::MU >= dgbs_pkg::WORD_W) ? '1 : ((64'd1 << dgbs_pkg::MU) - 64'd1);
    diff = (p ^ r) & mask;
    if (diff == '0) return 1'b1;
    low = diff & (~diff + 64'd1);
    return |(p & low);
  endfunction

  task automatic clear_trial_state();
    step_phase = 0;
    lap_bit    = 1'b0;
    geo_word   = '0;
    mag        = '0;
    sq_low     = '0;
    accept_ok  = 1'b1;
  endtask

  task automatic predict_trial_step(sampler_item_t it);
    bit b;
    int unsigned i;
    longint d;
    trial_sample_t r;
    if (it.kind == dgbs_pkg::FUNC_LOAD) begin
      if (it.idx < dgbs_pkg::TABLE_DEPTH) prob_words[it.idx] = it.word;
    end else if (trials_done < dgbs_pkg::TRIALS) begin
      if (step_phase == 0) begin
        lap_bit = bernoulli_bit(prob_words[0], it.word);
        step_phase = 1;
      end else if (step_phase <= dgbs_pkg::KAP) begin
        b = bernoulli_bit(prob_words[step_phase], it.word);
        geo_word[step_phase-1] = b;
        if (step_phase == dgbs_pkg::KAP) begin
          mag = lap_bit ? '0 : {1'b0, geo_word} + 1'b1;
          d = longint'(mag) - dgbs_pkg::SIGMA_CENTER;
          sq_low = 32'(d * d);
        end
        step_phase++;
      end else if (step_phase < dgbs_pkg::SIGN_PHASE) begin
        i = step_phase - 1 - dgbs_pkg::KAP;
        b = bernoulli_bit(prob_words[step_phase], it.word);
        if (sq_low[i] && !b) accept_ok = 1'b0;
        step_phase++;
      end else begin
        r.sample = dgbs_pkg::SAMPLE_W'(mag);
        if (it.word[0]) r.sample = -r.sample;
        r.accepted = accept_ok;
        r.sidx = dgbs_pkg::SIDX_W'(accepts_done);
        r.last = (trials_done == dgbs_pkg::TRIALS - 1);
        expected_samples.push_back(r);
        accepts_done += accept_ok;
        trials_done++;
        clear_trial_state();
      end
    end
  endtask

  initial begin
    foreach (prob_words[k]) prob_words[k] = '0;
    clear_trial_state();
    trials_done = 0;
    accepts_done = 0;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_trial_step(in_flight);
      if (!in_tvalid || in_tready) begin
        if (sampler_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = sampler_items.pop_front();
          in_tdata  <= {{(dgbs_pkg::IN_DATA_W-dgbs_pkg::IDX_W-dgbs_pkg::WORD_W){1'b0}},
                        in_flight.word, in_flight.idx};
          in_tuser  <= in_flight.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    trial_sample_t got;
    trial_sample_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.sample   = out_tdata[dgbs_pkg::SAMPLE_W-1:0];
        got.sidx     = out_tdata[dgbs_pkg::SAMPLE_W +: dgbs_pkg::SIDX_W];
        got.accepted = out_tuser;
        got.last     = out_tlast;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sample item: sample %0d accepted %0b index %0d last %0b",
                     $signed(got.sample), got.accepted, got.sidx, got.last);
        end else begin
          want = expected_samples.pop_front();
          if (got.sample !== want.sample || got.accepted !== want.accepted ||
              got.sidx !== want.sidx || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"sample mismatch: want sample %0d accepted %0b index %0d last %0b,",
                        " got sample %0d accepted %0b index %0d last %0b"},
                       $signed(want.sample), want.accepted, want.sidx, want.last,
                       $signed(got.sample), got.accepted, got.sidx, got.last);
          end
        end
      end
      out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL discrete_gaussian_bernoulli_sampler_core");
      $finish;
    end
  end

  function automatic bit [dgbs_pkg::WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(dgbs_pkg::func_t k, bit [dgbs_pkg::IDX_W-1:0] idx,
                           bit [dgbs_pkg::WORD_W-1:0] w);
    sampler_item_t it;
    it.kind = k;
    it.idx  = idx;
    it.word = w;
    sampler_items.push_back(it);
    gen_items++;
    if (k == dgbs_pkg::FUNC_LOAD) begin
      if (idx < dgbs_pkg::TABLE_DEPTH) gen_tab[idx] = w;
    end else if (gen_trials < dgbs_pkg::TRIALS) begin
      if (gen_ph == dgbs_pkg::SIGN_PHASE) begin
        gen_ph = 0;
        gen_trials++;
      end else begin
        gen_ph++;
      end
    end
  endtask

  // words near the table entry in use put the first difference anywhere
  task automatic push_random_word();
    bit [dgbs_pkg::WORD_W-1:0] near;
    bit [dgbs_pkg::WORD_W-1:0] w;
    int k;
    near = (gen_ph < dgbs_pkg::SIGN_PHASE) ? gen_tab[gen_ph] : rand_word();
    k = $urandom_range(dgbs_pkg::WORD_W - 1);
    case ($urandom_range(9))
      0: w = '0;
      1: w = '1;
      2: w = near;
      3: w = near ^ (64'd1 << k);
      4: w = near ^ ((rand_word() | (64'd1 << k)) & ~((64'd1 << k) - 64'd1));
      default: w = rand_word();
    endcase
    push_item(dgbs_pkg::FUNC_RAND, dgbs_pkg::IDX_W'($urandom_range(31)), w);
  endtask

  task automatic push_random_load();
    bit [dgbs_pkg::WORD_W-1:0] w;
    bit [dgbs_pkg::IDX_W-1:0] idx;
    case ($urandom_range(5))
      0: w = '0;
      1: w = '1;
      2: w = rand_word() & rand_word();
      3: w = rand_word() | rand_word();
      default: w = rand_word();
    endcase
    if ($urandom_range(7) == 0)
      idx = dgbs_pkg::IDX_W'($urandom_range(31, dgbs_pkg::TABLE_DEPTH));
    else idx = dgbs_pkg::IDX_W'($urandom_range(dgbs_pkg::TABLE_DEPTH - 1));
    push_item(dgbs_pkg::FUNC_LOAD, idx, w);
  endtask

  task automatic push_random_item();
    if ($urandom_range(99) < 8) push_random_load();
    else push_random_word();
  endtask

  task automatic set_idle(int mode);
    @(posedge clk);
    case (mode % 4)
      0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct <= 50; recv_stall_pct <= 0;  end
      2: begin send_idle_pct <= 0;  recv_stall_pct <= 50; end
      default: begin send_idle_pct <= 15; recv_stall_pct <= 15; end
    endcase
  endtask

  task automatic drain_all();
    while (sampler_items.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int mode;
    bit held;
    gen_ph = 0;
    gen_trials = 0;
    gen_items = 0;
    foreach (gen_tab[k]) gen_tab[k] = '0;
    mode = 0;
    held = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full table, ignored loads, extreme trials, load mid-trial
    push_item(dgbs_pkg::FUNC_LOAD, 0, '0);
    for (int i = 1; i < dgbs_pkg::TABLE_DEPTH; i++)
      push_item(dgbs_pkg::FUNC_LOAD, dgbs_pkg::IDX_W'(i), '1);
    push_item(dgbs_pkg::FUNC_LOAD, dgbs_pkg::IDX_W'(dgbs_pkg::TABLE_DEPTH), rand_word());
    push_item(dgbs_pkg::FUNC_LOAD, '1, rand_word());
    repeat (dgbs_pkg::SIGN_PHASE + 1) push_item(dgbs_pkg::FUNC_RAND, '0, '1);
    repeat (dgbs_pkg::SIGN_PHASE + 1) push_item(dgbs_pkg::FUNC_RAND, '1, '0);
    repeat (5) push_item(dgbs_pkg::FUNC_RAND, '0, '1);
    push_item(dgbs_pkg::FUNC_LOAD, dgbs_pkg::IDX_W'(dgbs_pkg::KAP + 1 + 4), '0);
    repeat (dgbs_pkg::SIGN_PHASE - 5) push_item(dgbs_pkg::FUNC_RAND, '0, '1);
    push_item(dgbs_pkg::FUNC_RAND, '0, '0);
    drain_all();

    while (gen_items < 1000) begin
      set_idle(mode);
      repeat (150) push_random_item();
      if (mode % 4 == 0 && !held) begin
        // receiver off for a long stretch, sender keeps offering
        held = 1'b1;
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
      while (sampler_items.size() != 0) @(posedge clk);
      mode++;
    end

    drain_all();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("PASS discrete_gaussian_bernoulli_sampler_core");
    end else begin
      $display("FAIL discrete_gaussian_bernoulli_sampler_core");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/dgbs_pkg.sv
hw/rtl/dgbs_front.sv
hw/rtl/dgbs_fifo.sv
hw/rtl/dgbs_back.sv
hw/rtl/discrete_gaussian_bernoulli_sampler_core.sv
sim/discrete_gaussian_bernoulli_sampler_core_test.sv
